[rtl/dbf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbf_pkg
// Shared types, codes and helpers for the deblocking edge filter.
// ----------------------------------------------------------------------------
package dbf_pkg;

  localparam int PIX_W = 8;
  localparam int OP_W  = 2;
  localparam int LIM_W = 6;

  typedef logic [PIX_W-1:0] pix_t;

  // opcodes
  localparam logic [OP_W-1:0] OP_MB_EDGE = 2'd0;
  localparam logic [OP_W-1:0] OP_INNER   = 2'd1;
  localparam logic [OP_W-1:0] OP_SIMPLE  = 2'd2;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_SHORT,
    MODE_INNER,
    MODE_WIDE
  } filt_mode_t;

  // six pixels that may change
  typedef struct packed {
    pix_t p2;
    pix_t p1;
    pix_t p0;
    pix_t q0;
    pix_t q1;
    pix_t q2;
  } line_t;

  function automatic pix_t abs_diff(input pix_t a, input pix_t b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic signed [7:0] sat_s8(input logic signed [10:0] v);
    if (v < -11'sd128) begin
      sat_s8 = -8'sd128;
    end else if (v > 11'sd127) begin
      sat_s8 = 8'sd127;
    end else begin
      sat_s8 = v[7:0];
    end
  endfunction

  function automatic pix_t sat_u8(input logic signed [9:0] v);
    if (v < 10'sd0) begin
      sat_u8 = 8'd0;
    end else if (v > 10'sd255) begin
      sat_u8 = 8'd255;
    end else begin
      sat_u8 = v[7:0];
    end
  endfunction

  function automatic pix_t apply_delta(input pix_t p, input logic signed [7:0] d,
                                       input logic sub);
    logic signed [9:0] px;
    logic signed [9:0] dx;
    px = $signed({2'b00, p});
    dx = {{2{d[7]}}, d};
    apply_delta = sat_u8(sub ? (px - dx) : (px + dx));
  endfunction

endpackage

[rtl/dbf_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbf_in_if / dbf_out_if
// Valid/ready channels for edge lines and filtered results.
// ----------------------------------------------------------------------------
interface dbf_in_if;
  import dbf_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  pix_t             pix_p3;
  pix_t             pix_p2;
  pix_t             pix_p1;
  pix_t             pix_p0;
  pix_t             pix_q0;
  pix_t             pix_q1;
  pix_t             pix_q2;
  pix_t             pix_q3;
  logic [7:0]       edge_limit;
  logic [LIM_W-1:0] interior_limit;
  logic [LIM_W-1:0] hev_threshold;

  modport source (output valid, opcode, pix_p3, pix_p2, pix_p1, pix_p0, pix_q0,
                  pix_q1, pix_q2, pix_q3, edge_limit, interior_limit,
                  hev_threshold, input ready);
  modport sink (input valid, opcode, pix_p3, pix_p2, pix_p1, pix_p0, pix_q0,
                pix_q1, pix_q2, pix_q3, edge_limit, interior_limit,
                hev_threshold, output ready);
endinterface

interface dbf_out_if;
  import dbf_pkg::*;

  logic valid;
  logic ready;
  pix_t out_p2;
  pix_t out_p1;
  pix_t out_p0;
  pix_t out_q0;
  pix_t out_q1;
  pix_t out_q2;
  logic was_filtered;

  modport source (output valid, out_p2, out_p1, out_p0, out_q0, out_q1, out_q2,
                  was_filtered, input ready);
  modport sink (input valid, out_p2, out_p1, out_p0, out_q0, out_q1, out_q2,
                was_filtered, output ready);
endinterface

[rtl/deblocking_edge_filter_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deblocking_edge_filter_top
// Loop filter for one line of eight pixels across a block edge.
//
//  channel   dir  handshake            payload
//  in_ch     in   valid/ready          opcode, p3..q3, E, I, hev threshold
//  out_ch    out  valid/ready          p2..q2 filtered, was_filtered
//
// Four register stages: limit tests, filter value, tap terms, apply + clamp
// into the output register. One transaction per cycle while out_ch is ready.
// Each stage advances when it is empty or the one after it advances, so a
// stall on out_ch backs up stage by stage and bubbles still fill.
// Reset (rst_n low, synchronous) clears only the stage valid bits.
// ----------------------------------------------------------------------------
module deblocking_edge_filter_top (
  input logic      clk,
  input logic      rst_n,
  dbf_in_if.sink   in_ch,
  dbf_out_if.source out_ch
);
  import dbf_pkg::*;

  // stage enables
  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;

  assign en4 = !v4_r || out_ch.ready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ch.ready = en1;

  // ---------------- stage 1: limit tests ----------------
  pix_t             ad_p3p2, ad_p2p1, ad_p1p0, ad_q3q2, ad_q2q1, ad_q1q0;
  pix_t             ad_p0q0, ad_p1q1;
  logic [9:0]       edge_sum;
  logic [7:0]       ilim, hlim;
  logic signed [8:0] diff_pq, diff_qp;

  line_t             line1_r;
  logic [OP_W-1:0]   op1_r;
  logic              edge_ok1_r, int_ok1_r, hev1_r;
  logic signed [7:0] cpq1_r;
  logic signed [8:0] d1_r;

  always_comb begin
    ad_p3p2  = abs_diff(in_ch.pix_p3, in_ch.pix_p2);
    ad_p2p1  = abs_diff(in_ch.pix_p2, in_ch.pix_p1);
    ad_p1p0  = abs_diff(in_ch.pix_p1, in_ch.pix_p0);
    ad_q3q2  = abs_diff(in_ch.pix_q3, in_ch.pix_q2);
    ad_q2q1  = abs_diff(in_ch.pix_q2, in_ch.pix_q1);
    ad_q1q0  = abs_diff(in_ch.pix_q1, in_ch.pix_q0);
    ad_p0q0  = abs_diff(in_ch.pix_p0, in_ch.pix_q0);
    ad_p1q1  = abs_diff(in_ch.pix_p1, in_ch.pix_q1);
    edge_sum = {1'b0, ad_p0q0, 1'b0} + {3'b000, ad_p1q1[7:1]};
    ilim     = {2'b00, in_ch.interior_limit};
    hlim     = {2'b00, in_ch.hev_threshold};
    diff_pq  = $signed({1'b0, in_ch.pix_p1}) - $signed({1'b0, in_ch.pix_q1});
    diff_qp  = $signed({1'b0, in_ch.pix_q0}) - $signed({1'b0, in_ch.pix_p0});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      line1_r    <= '{p2: in_ch.pix_p2, p1: in_ch.pix_p1, p0: in_ch.pix_p0,
                      q0: in_ch.pix_q0, q1: in_ch.pix_q1, q2: in_ch.pix_q2};
      op1_r      <= in_ch.opcode;
      edge_ok1_r <= (edge_sum <= {2'b00, in_ch.edge_limit});
      int_ok1_r  <= (ad_p3p2 <= ilim) && (ad_p2p1 <= ilim) && (ad_p1p0 <= ilim) &&
                    (ad_q3q2 <= ilim) && (ad_q2q1 <= ilim) && (ad_q1q0 <= ilim);
      hev1_r     <= (ad_p1p0 > hlim) || (ad_q1q0 > hlim);
      cpq1_r     <= sat_s8({{2{diff_pq[8]}}, diff_pq});
      d1_r       <= diff_qp;
    end
  end

  // ---------------- stage 2: mode and filter value ----------------
  logic signed [10:0] d_x, d_3x, outer_sum;
  logic signed [7:0]  a_outer, a_inner;
  filt_mode_t         mode2_nxt;

  line_t             line2_r;
  logic [OP_W-1:0]   op2_r;
  filt_mode_t        mode2_r;
  logic signed [7:0] a2_r;

  always_comb begin
    d_x       = {{2{d1_r[8]}}, d1_r};
    d_3x      = d_x + (d_x <<< 1);
    outer_sum = {{3{cpq1_r[7]}}, cpq1_r} + d_3x;
    a_outer   = sat_s8(outer_sum);
    a_inner   = sat_s8(d_3x);

    unique case (op1_r) inside
      OP_MB_EDGE, OP_INNER: begin
        if (edge_ok1_r && int_ok1_r) begin
          if (hev1_r) begin
            mode2_nxt = MODE_SHORT;
          end else if (op1_r == OP_MB_EDGE) begin
            mode2_nxt = MODE_WIDE;
          end else begin
            mode2_nxt = MODE_INNER;
          end
        end else begin
          mode2_nxt = MODE_NONE;
        end
      end
      OP_SIMPLE: begin
        mode2_nxt = edge_ok1_r ? MODE_SHORT : MODE_NONE;
      end
      default: begin
        mode2_nxt = MODE_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      line2_r <= line1_r;
      op2_r   <= op1_r;
      mode2_r <= mode2_nxt;
      a2_r    <= (mode2_nxt == MODE_INNER) ? a_inner : a_outer;
    end
  end

  // ---------------- stage 3: tap terms ----------------
  logic signed [8:0]  a_x, t4, t3;
  logic signed [7:0]  f1, f2, f1p, f3;
  logic signed [12:0] w_x, w27, w18, w9;
  logic signed [7:0]  wa0, wa1, wa2;
  logic signed [7:0]  dp0_nxt, dq0_nxt, dt1_nxt, dt2_nxt;

  line_t             line3_r;
  filt_mode_t        mode3_r;
  logic signed [7:0] dp0_r, dq0_r, dt1_r, dt2_r;

  always_comb begin
    a_x = {a2_r[7], a2_r};
    t4  = a_x + 9'sd4;
    t3  = a_x + 9'sd3;
    if (t4 > 9'sd127) t4 = 9'sd127;
    if (t3 > 9'sd127) t3 = 9'sd127;
    f1  = 8'(t4 >>> 3);
    f2  = 8'(t3 >>> 3);
    f1p = f1 + 8'sd1;
    f3  = f1p >>> 1;

    // round-half-down taps of the wide filter: (k*w + 63) >> 7
    w_x = {{5{a2_r[7]}}, a2_r};
    w27 = w_x * 13'sd27 + 13'sd63;
    w18 = w_x * 13'sd18 + 13'sd63;
    w9  = w_x * 13'sd9 + 13'sd63;
    wa0 = 8'(w27 >>> 7);
    wa1 = 8'(w18 >>> 7);
    wa2 = 8'(w9 >>> 7);

    unique case (mode2_r)
      MODE_SHORT: begin
        dp0_nxt = f2;  dq0_nxt = f1;  dt1_nxt = 8'sd0; dt2_nxt = 8'sd0;
      end
      MODE_INNER: begin
        dp0_nxt = f2;  dq0_nxt = f1;  dt1_nxt = f3;    dt2_nxt = 8'sd0;
      end
      MODE_WIDE: begin
        dp0_nxt = wa0; dq0_nxt = wa0; dt1_nxt = wa1;   dt2_nxt = wa2;
      end
      default: begin
        dp0_nxt = 8'sd0; dq0_nxt = 8'sd0; dt1_nxt = 8'sd0; dt2_nxt = 8'sd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      line3_r <= line2_r;
      mode3_r <= mode2_r;
      dp0_r   <= dp0_nxt;
      dq0_r   <= dq0_nxt;
      dt1_r   <= dt1_nxt;
      dt2_r   <= dt2_nxt;
    end
  end

  // ---------------- stage 4: apply and clamp ----------------
  line_t line4_r;
  logic  filt4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      line4_r.p2 <= apply_delta(line3_r.p2, dt2_r, 1'b0);
      line4_r.p1 <= apply_delta(line3_r.p1, dt1_r, 1'b0);
      line4_r.p0 <= apply_delta(line3_r.p0, dp0_r, 1'b0);
      line4_r.q0 <= apply_delta(line3_r.q0, dq0_r, 1'b1);
      line4_r.q1 <= apply_delta(line3_r.q1, dt1_r, 1'b1);
      line4_r.q2 <= apply_delta(line3_r.q2, dt2_r, 1'b1);
      filt4_r    <= (mode3_r != MODE_NONE);
    end
  end

  assign out_ch.valid        = v4_r;
  assign out_ch.out_p2       = line4_r.p2;
  assign out_ch.out_p1       = line4_r.p1;
  assign out_ch.out_p0       = line4_r.p0;
  assign out_ch.out_q0       = line4_r.q0;
  assign out_ch.out_q1       = line4_r.q1;
  assign out_ch.out_q2       = line4_r.q2;
  assign out_ch.was_filtered = filt4_r;

  // ---------------- checks ----------------
  a_none_no_delta: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && mode3_r == MODE_NONE) |->
      (dp0_r == 8'sd0 && dq0_r == 8'sd0 && dt1_r == 8'sd0 && dt2_r == 8'sd0))
    else $error("unfiltered line carries a nonzero tap");

  a_simple_short_only: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && op2_r == OP_SIMPLE) |-> (mode2_r == MODE_NONE || mode2_r == MODE_SHORT))
    else $error("simple mode selected a normal-mode filter");

  a_stage3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !en4) |=> (v3_r && $stable(dp0_r) && $stable(line3_r)))
    else $error("stage 3 changed while stalled");

  a_short_keeps_outer: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && mode3_r != MODE_WIDE) |-> (dt2_r == 8'sd0))
    else $error("outer pixels moved outside the wide filter");

endmodule

[bench/tb_deblocking_edge_filter_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_deblocking_edge_filter_top
// Self-checking bench for the deblocking edge filter. Every accepted edge
// line is run through a local line-filter predictor and the expected six
// pixels plus filter flag are queued, then compared in order with each
// result transaction. Directed lines hit every mode and limit boundary;
// random lines are mostly smooth edges with limits near their thresholds.
// Both channels idle at random; one phase holds the output off for a long
// stretch and one phase lets the pipeline drain before sending more.
// ----------------------------------------------------------------------------
module tb_deblocking_edge_filter_top;
  import dbf_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int LONG_HOLD   = 80;
  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_TAIL  = 20;

  typedef struct {
    logic [OP_W-1:0]  opcode;
    pix_t             p3, p2, p1, p0, q0, q1, q2, q3;
    logic [7:0]       edge_lim;
    logic [LIM_W-1:0] inner_lim;
    logic [LIM_W-1:0] hev_thr;
  } edge_line_t;

  typedef struct {
    pix_t p2, p1, p0, q0, q1, q2;
    logic filtered;
  } line_result_t;

  typedef enum {SINK_STEADY, SINK_LIGHT, SINK_HEAVY} sink_style_t;

  logic clk = 1'b0;
  logic rst_n;

  dbf_in_if  in_if ();
  dbf_out_if out_if ();

  deblocking_edge_filter_top uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  line_result_t pending_lines[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int stall_requests = 0;
  int stall_seen = 0;
  int hold_left = 0;
  int style_left = 0;
  sink_style_t sink_style = SINK_STEADY;

  // ---------------- line filter predictor ----------------

  function automatic int clamp_int(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int pix_gap(pix_t a, pix_t b);
    int d;
    d = int'(a) - int'(b);
    return (d < 0) ? -d : d;
  endfunction

  function automatic int edge_activity(edge_line_t ln);
    return 2 * pix_gap(ln.p0, ln.q0) + (pix_gap(ln.p1, ln.q1) >> 1);
  endfunction

  function automatic int interior_spread(edge_line_t ln);
    int m;
    m = pix_gap(ln.p3, ln.p2);
    if (pix_gap(ln.p2, ln.p1) > m) m = pix_gap(ln.p2, ln.p1);
    if (pix_gap(ln.p1, ln.p0) > m) m = pix_gap(ln.p1, ln.p0);
    if (pix_gap(ln.q3, ln.q2) > m) m = pix_gap(ln.q3, ln.q2);
    if (pix_gap(ln.q2, ln.q1) > m) m = pix_gap(ln.q2, ln.q1);
    if (pix_gap(ln.q1, ln.q0) > m) m = pix_gap(ln.q1, ln.q0);
    return m;
  endfunction

  function automatic int hev_level(edge_line_t ln);
    int a;
    int b;
    a = pix_gap(ln.p1, ln.p0);
    b = pix_gap(ln.q1, ln.q0);
    return (a > b) ? a : b;
  endfunction

  function automatic int cap127(int v);
    return (v > 127) ? 127 : v;
  endfunction

  function automatic line_result_t filter_line(edge_line_t ln);
    int p2, p1, p0, q0, q1, q2;
    int a, f1, f2, u, w;
    logic hev;
    line_result_t r;
    p2 = ln.p2; p1 = ln.p1; p0 = ln.p0;
    q0 = ln.q0; q1 = ln.q1; q2 = ln.q2;
    hev = hev_level(ln) > int'(ln.hev_thr);
    case (ln.opcode) inside
      OP_MB_EDGE, OP_INNER: r.filtered = (edge_activity(ln) <= int'(ln.edge_lim)) &&
                                         (interior_spread(ln) <= int'(ln.inner_lim));
      OP_SIMPLE:            r.filtered = edge_activity(ln) <= int'(ln.edge_lim);
      default:              r.filtered = 1'b0;
    endcase
    if (r.filtered) begin
      if (ln.opcode == OP_MB_EDGE && !hev) begin
        w  = clamp_int(clamp_int(p1 - q1, -128, 127) + 3 * (q0 - p0), -128, 127);
        a  = (27 * w + 63) >>> 7;
        f1 = (18 * w + 63) >>> 7;
        f2 = (9 * w + 63) >>> 7;
        p0 = p0 + a;  q0 = q0 - a;
        p1 = p1 + f1; q1 = q1 - f1;
        p2 = p2 + f2; q2 = q2 - f2;
      end else if (ln.opcode == OP_INNER && !hev) begin
        a  = clamp_int(3 * (q0 - p0), -128, 127);
        f1 = cap127(a + 4) >>> 3;
        f2 = cap127(a + 3) >>> 3;
        u  = (f1 + 1) >>> 1;
        p0 = p0 + f2; q0 = q0 - f1;
        p1 = p1 + u;  q1 = q1 - u;
      end else begin
        // 4-tap filter: high edge variance in the normal modes, always in simple
        a  = clamp_int(clamp_int(p1 - q1, -128, 127) + 3 * (q0 - p0), -128, 127);
        f1 = cap127(a + 4) >>> 3;
        f2 = cap127(a + 3) >>> 3;
        p0 = p0 + f2; q0 = q0 - f1;
      end
    end
    r.p2 = pix_t'(clamp_int(p2, 0, 255));
    r.p1 = pix_t'(clamp_int(p1, 0, 255));
    r.p0 = pix_t'(clamp_int(p0, 0, 255));
    r.q0 = pix_t'(clamp_int(q0, 0, 255));
    r.q1 = pix_t'(clamp_int(q1, 0, 255));
    r.q2 = pix_t'(clamp_int(q2, 0, 255));
    return r;
  endfunction

  // ---------------- line generation ----------------

  function automatic int jitter(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic int burst_len();
    return ($urandom_range(0, 4) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
  endfunction

  function automatic int pick_gap();
    return ($urandom_range(0, 9) < 7) ? 0 : burst_len();
  endfunction

  function automatic logic [OP_W-1:0] pick_opcode();
    int r;
    r = $urandom_range(0, 30);
    if (r == 0) return OP_UNUSED;
    if (r <= 10) return OP_MB_EDGE;
    if (r <= 20) return OP_INNER;
    return OP_SIMPLE;
  endfunction

  function automatic edge_line_t make_line(logic [OP_W-1:0] op, int a3, int a2, int a1,
                                           int a0, int b0, int b1, int b2, int b3,
                                           int e, int i, int t);
    edge_line_t ln;
    ln.opcode = op;
    ln.p3 = pix_t'(a3); ln.p2 = pix_t'(a2); ln.p1 = pix_t'(a1); ln.p0 = pix_t'(a0);
    ln.q0 = pix_t'(b0); ln.q1 = pix_t'(b1); ln.q2 = pix_t'(b2); ln.q3 = pix_t'(b3);
    ln.edge_lim  = 8'(e);
    ln.inner_lim = LIM_W'(i);
    ln.hev_thr   = LIM_W'(t);
    return ln;
  endfunction

  function automatic edge_line_t noise_line();
    return make_line(pick_opcode(), $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom_range(0, 63), $urandom_range(0, 63));
  endfunction

  // Smooth line with a step at the edge; limits land near the line's own
  // metrics so both sides of every threshold get hit.
  function automatic edge_line_t smooth_line();
    int base, step, jump, k, e, i, t;
    int v[8];
    edge_line_t ln;
    case ($urandom_range(0, 7))
      0:       base = $urandom_range(0, 8);
      1:       base = $urandom_range(247, 255);
      default: base = $urandom_range(0, 255);
    endcase
    step = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 25) : $urandom_range(0, 6);
    jump = ($urandom_range(0, 4) == 0) ? jitter(127) : jitter(30);
    v[3] = base;
    v[4] = clamp_int(base + jump, 0, 255);
    for (k = 2; k >= 0; k--) v[k] = clamp_int(v[k + 1] + jitter(step), 0, 255);
    for (k = 5; k <= 7; k++) v[k] = clamp_int(v[k - 1] + jitter(step), 0, 255);
    ln = make_line(pick_opcode(), v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], 0, 0, 0);
    e = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
                                    : clamp_int(edge_activity(ln) + jitter(4), 0, 255);
    i = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 63)
                                    : clamp_int(interior_spread(ln) + jitter(3), 0, 63);
    t = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                    : clamp_int(hev_level(ln) + jitter(3), 0, 63);
    ln.edge_lim  = 8'(e);
    ln.inner_lim = LIM_W'(i);
    ln.hev_thr   = LIM_W'(t);
    return ln;
  endfunction

  // ---------------- line source ----------------

  // Called at a rising edge; returns at the edge where the line is taken.
  task automatic send_line(edge_line_t ln, int gap);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.opcode         <= ln.opcode;
    in_if.pix_p3         <= ln.p3;
    in_if.pix_p2         <= ln.p2;
    in_if.pix_p1         <= ln.p1;
    in_if.pix_p0         <= ln.p0;
    in_if.pix_q0         <= ln.q0;
    in_if.pix_q1         <= ln.q1;
    in_if.pix_q2         <= ln.q2;
    in_if.pix_q3         <= ln.q3;
    in_if.edge_limit     <= ln.edge_lim;
    in_if.interior_limit <= ln.inner_lim;
    in_if.hev_threshold  <= ln.hev_thr;
    in_if.valid          <= 1'b1;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic stop_sending();
    in_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------- result sink ----------------

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_left = 0;
      style_left = 0;
    end else if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left--;
    end else if (stall_seen != stall_requests) begin
      stall_seen = stall_requests;
      hold_left = LONG_HOLD - 1;
      out_if.ready <= 1'b0;
    end else begin
      if (style_left == 0) begin
        case ($urandom_range(0, 2))
          0:       sink_style = SINK_STEADY;
          1:       sink_style = SINK_LIGHT;
          default: sink_style = SINK_HEAVY;
        endcase
        style_left = $urandom_range(50, 300);
      end else begin
        style_left--;
      end
      if ((sink_style == SINK_LIGHT && $urandom_range(0, 5) == 0) ||
          (sink_style == SINK_HEAVY && $urandom_range(0, 1) == 0)) begin
        hold_left = burst_len() - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // ---------------- monitor, checker and watchdog ----------------

  always @(posedge clk) begin
    edge_line_t seen;
    line_result_t want;
    logic moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        seen.opcode    = in_if.opcode;
        seen.p3        = in_if.pix_p3;
        seen.p2        = in_if.pix_p2;
        seen.p1        = in_if.pix_p1;
        seen.p0        = in_if.pix_p0;
        seen.q0        = in_if.pix_q0;
        seen.q1        = in_if.pix_q1;
        seen.q2        = in_if.pix_q2;
        seen.q3        = in_if.pix_q3;
        seen.edge_lim  = in_if.edge_limit;
        seen.inner_lim = in_if.interior_limit;
        seen.hev_thr   = in_if.hev_threshold;
        pending_lines.push_back(filter_line(seen));
        moved = 1'b1;
      end
      if (out_if.valid && out_if.ready) begin
        moved = 1'b1;
        if (pending_lines.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result transaction with no line outstanding", $time);
        end else begin
          want = pending_lines.pop_front();
          if (out_if.out_p2 !== want.p2 || out_if.out_p1 !== want.p1 ||
              out_if.out_p0 !== want.p0 || out_if.out_q0 !== want.q0 ||
              out_if.out_q1 !== want.q1 || out_if.out_q2 !== want.q2 ||
              out_if.was_filtered !== want.filtered) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch exp p2 %0d p1 %0d p0 %0d q0 %0d q1 %0d q2 %0d flt %0d",
                       $time, want.p2, want.p1, want.p0, want.q0, want.q1, want.q2,
                       want.filtered);
              $display("%0t:          got p2 %0d p1 %0d p0 %0d q0 %0d q1 %0d q2 %0d flt %0d",
                       $time, out_if.out_p2, out_if.out_p1, out_if.out_p0, out_if.out_q0,
                       out_if.out_q1, out_if.out_q2, out_if.was_filtered);
            end
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb_deblocking_edge_filter_top: done, errors");
        $finish;
      end
    end
  end

  // ---------------- tests ----------------

  task automatic test_directed_modes();
    edge_line_t lines[$];
    lines.push_back(make_line(OP_MB_EDGE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    lines.push_back(make_line(OP_INNER, 255, 255, 255, 255, 255, 255, 255, 255, 0, 0, 0));
    // wide filter, then edge limit one below and exactly at the edge activity
    lines.push_back(make_line(OP_MB_EDGE, 100, 100, 100, 100, 110, 110, 110, 110, 255, 63, 63));
    lines.push_back(make_line(OP_MB_EDGE, 100, 100, 100, 100, 110, 110, 110, 110, 24, 63, 63));
    lines.push_back(make_line(OP_MB_EDGE, 100, 100, 100, 100, 110, 110, 110, 110, 25, 63, 63));
    // high edge variance takes the 4-tap path in both normal modes
    lines.push_back(make_line(OP_MB_EDGE, 100, 100, 100, 120, 130, 130, 130, 130, 255, 63, 5));
    lines.push_back(make_line(OP_INNER, 100, 100, 100, 120, 130, 130, 130, 130, 255, 63, 5));
    lines.push_back(make_line(OP_INNER, 80, 80, 80, 80, 90, 90, 90, 90, 40, 10, 10));
    lines.push_back(make_line(OP_INNER, 90, 90, 90, 90, 80, 80, 80, 80, 40, 10, 10));
    lines.push_back(make_line(OP_MB_EDGE, 60, 60, 60, 60, 0, 0, 0, 0, 200, 0, 0));
    // simple mode ignores the interior and variance limits
    lines.push_back(make_line(OP_SIMPLE, 0, 255, 90, 100, 110, 0, 255, 3, 255, 0, 0));
    lines.push_back(make_line(OP_SIMPLE, 0, 255, 90, 100, 110, 0, 255, 3, 10, 0, 0));
    lines.push_back(make_line(OP_UNUSED, 100, 100, 100, 100, 110, 110, 110, 110, 255, 63, 63));
    // interior limit boundary
    lines.push_back(make_line(OP_MB_EDGE, 107, 100, 100, 100, 110, 110, 110, 110, 255, 6, 63));
    lines.push_back(make_line(OP_MB_EDGE, 107, 100, 100, 100, 110, 110, 110, 110, 255, 7, 63));
    // variance threshold boundary
    lines.push_back(make_line(OP_INNER, 100, 100, 100, 104, 110, 114, 114, 114, 255, 63, 4));
    lines.push_back(make_line(OP_INNER, 100, 100, 100, 104, 110, 114, 114, 114, 255, 63, 3));
    // saturated filter value, pixel clamps at 255 and at 0
    lines.push_back(make_line(OP_SIMPLE, 0, 0, 255, 250, 250, 100, 0, 0, 255, 0, 0));
    lines.push_back(make_line(OP_SIMPLE, 0, 0, 0, 5, 5, 155, 0, 0, 255, 0, 0));
    lines.push_back(make_line(OP_MB_EDGE, 255, 255, 255, 255, 200, 200, 200, 200, 255, 63, 63));
    lines.push_back(make_line(OP_INNER, 0, 63, 126, 189, 189, 252, 252, 252, 63, 63, 62));
    foreach (lines[n]) send_line(lines[n], pick_gap());
    stop_sending();
  endtask

  task automatic test_output_backpressure();
    stall_requests++;
    repeat (40) send_line(smooth_line(), 0);
    stop_sending();
  endtask

  task automatic test_drain_pause();
    repeat (20) send_line(smooth_line(), pick_gap());
    stop_sending();
    while (pending_lines.size() != 0) @(posedge clk);
    repeat (20) send_line(smooth_line(), 0);
    stop_sending();
  endtask

  task automatic test_random_lines(int count);
    logic gaps_on;
    edge_line_t ln;
    gaps_on = 1'b1;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      ln = ($urandom_range(0, 3) == 0) ? noise_line() : smooth_line();
      send_line(ln, gaps_on ? pick_gap() : 0);
    end
    stop_sending();
  endtask

  initial begin
    rst_n                = 1'b0;
    in_if.valid          = 1'b0;
    in_if.opcode         = OP_MB_EDGE;
    in_if.pix_p3         = '0;
    in_if.pix_p2         = '0;
    in_if.pix_p1         = '0;
    in_if.pix_p0         = '0;
    in_if.pix_q0         = '0;
    in_if.pix_q1         = '0;
    in_if.pix_q2         = '0;
    in_if.pix_q3         = '0;
    in_if.edge_limit     = '0;
    in_if.interior_limit = '0;
    in_if.hev_threshold  = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_modes();
    test_output_backpressure();
    test_drain_pause();
    test_random_lines(850);

    while (pending_lines.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatches == 0 && pending_lines.size() == 0) begin
      $display("tb_deblocking_edge_filter_top: done, clean");
    end else begin
      $display("tb_deblocking_edge_filter_top: done, errors");
    end
    $finish;
  end

endmodule
